[rtl/core/dlq_pkg.sv]
// ----------------------------------------------------------------------------
// dlq_pkg: shared types and constants for the delimited line queue
// Byte codes, field widths and the packed result word.
// ----------------------------------------------------------------------------
package dlq_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned WAIT_W = 4;

  localparam logic [BYTE_W-1:0] CHAR_CR   = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_LF   = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_SEMI = 8'h3B;
  localparam logic [BYTE_W-1:0] CHAR_NUL  = 8'h00;

  localparam logic MODE_RX   = 1'b0;
  localparam logic MODE_READ = 1'b1;

  typedef logic [BYTE_W-1:0] byte_t;

  // flags of one result word; the read character joins from the line store
  typedef struct packed {
    logic              echo_valid;
    byte_t             echo_byte;
    logic              line_queued;
    logic              line_dropped;
    logic              char_dropped;
    logic              char_valid;
    logic              line_end;
    logic              queue_empty;
    logic [WAIT_W-1:0] lines_waiting;
  } res_t;

  function automatic logic is_delim(byte_t b);
    return (b == CHAR_CR) || (b == CHAR_LF) || (b == CHAR_SEMI);
  endfunction

endpackage

[rtl/core/dlq_line_store.sv]
// ----------------------------------------------------------------------------
// dlq_line_store: text memory for all queue slots
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dlq_line_store
  import dlq_pkg::*;
#(
  parameter int unsigned LINE_BYTES = 128,
  parameter int unsigned SLOTS      = 9,
  parameter int unsigned SLOT_W     = 4,
  parameter int unsigned POS_W      = 7
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [SLOT_W-1:0] wr_slot,
  input  logic [POS_W-1:0]  wr_pos,
  input  byte_t             wr_data,
  input  logic              rd_en,
  input  logic [SLOT_W-1:0] rd_slot,
  input  logic [POS_W-1:0]  rd_pos,
  output byte_t             rd_data
);

  localparam int unsigned DEPTH  = SLOTS * LINE_BYTES;
  localparam int unsigned ADDR_W = $clog2(DEPTH);

  byte_t             mem [DEPTH];
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;

  assign wr_addr = ADDR_W'(wr_slot) * ADDR_W'(LINE_BYTES) + ADDR_W'(wr_pos);
  assign rd_addr = ADDR_W'(rd_slot) * ADDR_W'(LINE_BYTES) + ADDR_W'(rd_pos);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/core/delimited_line_queue_core.sv]
// ----------------------------------------------------------------------------
// delimited_line_queue_core: line assembler with a queue of finished lines
// Latency: the result word is valid the cycle after its input word is taken.
// Throughput: one word per cycle unless m_tready holds the output; the text memory takes at most one access per word.
// Reset clears the ring pointers, counters and output valid; the text memory
// and slot lengths are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module delimited_line_queue_core
  import dlq_pkg::*;
#(
  parameter int unsigned LINE_BYTES  = 128,
  parameter int unsigned QUEUE_LINES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic        s_tuser,   // [0] mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // [0] echo_valid, [8:1] echo_byte, [9] line_queued,
                                 // [10] line_dropped, [11] char_dropped, [12] char_valid,
                                 // [20:13] line_char, [21] line_end, [22] queue_empty,
                                 // [26:23] lines_waiting, [31:27] zero
);

  localparam int unsigned SLOTS  = QUEUE_LINES + 1;
  localparam int unsigned SLOT_W = $clog2(SLOTS);
  localparam int unsigned POS_W  = $clog2(LINE_BYTES);
  localparam int unsigned CNT_W  = $clog2(QUEUE_LINES + 1);

  localparam logic [POS_W-1:0]  MAX_LEN  = POS_W'(LINE_BYTES - 1);
  localparam logic [CNT_W-1:0]  FULL_CNT = CNT_W'(QUEUE_LINES);
  localparam logic [SLOT_W-1:0] LAST_SLT = SLOT_W'(SLOTS - 1);

  // ring and assembly state
  logic [SLOT_W-1:0] head_slot,  head_slot_next;
  logic [SLOT_W-1:0] tail_slot,  tail_slot_next;
  logic [CNT_W-1:0]  queued,     queued_next;
  logic [POS_W-1:0]  rcv_len,    rcv_len_next;
  logic [POS_W-1:0]  stored_len, stored_len_next;
  logic              text_ended, text_ended_next;
  logic [POS_W-1:0]  read_pos,   read_pos_next;
  logic [POS_W-1:0]  slot_len [SLOTS];

  res_t  res, res_next;
  logic  accept;
  logic  mode;
  byte_t rx;
  logic  wr_en, rd_en, len_wr;
  byte_t rd_data;

  logic [POS_W-1:0]  head_len;
  logic [POS_W-1:0]  read_pos_inc;
  logic [CNT_W+3:0]  queued_wide;

  assign mode     = s_tuser;
  assign rx       = s_tdata;
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  assign head_len     = slot_len[head_slot];
  assign read_pos_inc = read_pos + POS_W'(1);

  function automatic logic [SLOT_W-1:0] slot_inc(logic [SLOT_W-1:0] s);
    return (s == LAST_SLT) ? '0 : s + SLOT_W'(1);
  endfunction

  always_comb begin
    head_slot_next  = head_slot;
    tail_slot_next  = tail_slot;
    queued_next     = queued;
    rcv_len_next    = rcv_len;
    stored_len_next = stored_len;
    text_ended_next = text_ended;
    read_pos_next   = read_pos;
    res_next        = '0;
    wr_en           = 1'b0;
    rd_en           = 1'b0;
    len_wr          = 1'b0;
    queued_wide     = '0;

    unique case (mode)
      MODE_RX: begin
        res_next.echo_valid = 1'b1;
        res_next.echo_byte  = rx;
        if (is_delim(rx)) begin
          if (rcv_len != '0) begin
            if (queued == FULL_CNT) begin
              res_next.line_dropped = 1'b1;
            end else begin
              len_wr               = 1'b1;
              tail_slot_next       = slot_inc(tail_slot);
              queued_next          = queued + CNT_W'(1);
              res_next.line_queued = 1'b1;
            end
            rcv_len_next    = '0;
            stored_len_next = '0;
            text_ended_next = 1'b0;
          end
        end else if (rcv_len < MAX_LEN) begin
          rcv_len_next = rcv_len + POS_W'(1);
          if (!text_ended) begin
            if (rx == CHAR_NUL) begin
              text_ended_next = 1'b1;
            end else begin
              // stored length never passes the received count, so it fits
              wr_en           = 1'b1;
              stored_len_next = stored_len + POS_W'(1);
            end
          end
        end else begin
          res_next.char_dropped = 1'b1;
        end
      end
      MODE_READ: begin
        if (queued == '0) begin
          res_next.queue_empty = 1'b1;
        end else begin
          if (read_pos < head_len) begin
            rd_en               = 1'b1;
            res_next.char_valid = 1'b1;
            read_pos_next       = read_pos_inc;
          end
          if (read_pos_inc >= head_len || head_len == '0) begin
            res_next.line_end = 1'b1;
            head_slot_next    = slot_inc(head_slot);
            queued_next       = queued - CNT_W'(1);
            read_pos_next     = '0;
          end
        end
      end
      default: begin
      end
    endcase

    queued_wide            = {4'b0, queued_next};
    res_next.lines_waiting = queued_wide[3:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_slot  <= '0;
      tail_slot  <= '0;
      queued     <= '0;
      rcv_len    <= '0;
      stored_len <= '0;
      text_ended <= 1'b0;
      read_pos   <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (accept) begin
        head_slot  <= head_slot_next;
        tail_slot  <= tail_slot_next;
        queued     <= queued_next;
        rcv_len    <= rcv_len_next;
        stored_len <= stored_len_next;
        text_ended <= text_ended_next;
        read_pos   <= read_pos_next;
        m_tvalid   <= 1'b1;
      end else if (m_tready) begin
        m_tvalid   <= 1'b0;
      end
    end
  end

  // payload: result flags and slot lengths
  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
    if (accept && len_wr) begin
      slot_len[tail_slot] <= stored_len;
    end
  end

  dlq_line_store #(
    .LINE_BYTES (LINE_BYTES),
    .SLOTS      (SLOTS),
    .SLOT_W     (SLOT_W),
    .POS_W      (POS_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (accept && wr_en),
    .wr_slot (tail_slot),
    .wr_pos  (stored_len),
    .wr_data (rx),
    .rd_en   (accept && rd_en),
    .rd_slot (head_slot),
    .rd_pos  (read_pos),
    .rd_data (rd_data)
  );

  assign m_tdata = {5'b0,
                    res.lines_waiting,
                    res.queue_empty,
                    res.line_end,
                    res.char_valid ? rd_data : CHAR_NUL,
                    res.char_valid,
                    res.char_dropped,
                    res.line_dropped,
                    res.line_queued,
                    res.echo_byte,
                    res.echo_valid};

endmodule
